// File: hw/rtl/ffea_pkg.sv
// ----------------------------------------------------------------------------
// ffea_pkg: shared types and constants of the first-fit extent allocator
// Extent record, request/response beats, operation and status codes.
// ----------------------------------------------------------------------------
package ffea_pkg;

  // table geometry
  localparam int MaxExtents = 32;
  localparam int IdxW       = $clog2(MaxExtents);
  localparam int CntW       = $clog2(MaxExtents + 1);
  localparam int GranW      = 20;
  localparam int SizeW      = 20;
  localparam int LenW       = 21;
  localparam int BytesW     = 24;
  localparam int ReqGW      = 21;

  localparam logic [GranW-1:0] AddrMask = '1;
  localparam logic [SizeW:0]   SizeMax  = {1'b0, {SizeW{1'b1}}};

  // operation codes
  localparam logic [1:0] FnAlloc = 2'd0;
  localparam logic [1:0] FnFree  = 2'd1;
  localparam logic [1:0] FnInit  = 2'd2;

  // status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StIgn   = 2'd1;
  localparam logic [1:0] StNoFit = 2'd2;
  localparam logic [1:0] StFull  = 2'd3;

  // one free extent: header granule and payload size
  typedef struct packed {
    logic [GranW-1:0] start;
    logic [SizeW-1:0] size;
  } extent_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [BytesW-1:0] request_bytes;
    logic [GranW-1:0]  block_addr;
    logic [SizeW-1:0]  block_granules;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [GranW-1:0] grant_addr;
    logic [SizeW-1:0] grant_granules;
  } rsp_t;

endpackage

// File: hw/rtl/first_fit_extent_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_core: first-fit allocator with coalescing
// Alloc makes one full rotation of the extent ring, one entry per cycle; free
//   runs a prep step and then the same rotation; a free refused at the head
//   of a full table, init, zero request, null free and unused codes skip the
//   rotation. One operation at a time; the next beat is taken while a result
//   waits.
// Reset: extent table empty, base granule 1, length 4096; ring data not cleared.
// ----------------------------------------------------------------------------
module first_fit_extent_allocator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ffea_pkg::req_t             in_data_i,
  // response channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ffea_pkg::rsp_t             out_data_o,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int N = ffea_pkg::MaxExtents;

  // sequencer states
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SPrep = 2'd1;
  localparam logic [1:0] SScan = 2'd2;
  localparam logic [1:0] SDone = 2'd3;

  // per-cycle ring edit modes
  localparam logic [2:0] PCopy  = 3'd0;
  localparam logic [2:0] PSkip  = 3'd1;
  localparam logic [2:0] PSubst = 3'd2;
  localparam logic [2:0] PIns   = 3'd3;
  localparam logic [2:0] PCarry = 3'd4;

  // ---------------------------------------------------------------- config
  logic [ffea_pkg::GranW-1:0] base_q;
  logic [ffea_pkg::LenW-1:0]  len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= ffea_pkg::GranW'(1);
      len_q  <= ffea_pkg::LenW'(4096);
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        len_q <= pwdata[ffea_pkg::LenW-1:0];
      end else begin
        base_q <= pwdata[ffea_pkg::GranW-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'(len_q) : 32'(base_q);

  // ---------------------------------------------------------------- registers
  logic [1:0]                 state_q, state_d;
  logic [1:0]                 func_q, func_d;
  logic [ffea_pkg::ReqGW-1:0] g_q, g_d;
  logic [ffea_pkg::SizeW-1:0] bs_q, bs_d;
  logic [ffea_pkg::GranW-1:0] hdr_q, hdr_d;
  logic [ffea_pkg::LenW-1:0]  end_q, end_d;
  logic                       found_q, found_d;
  logic [2:0]                 pend_q, pend_d;
  ffea_pkg::extent_t          carry_q, carry_d;
  ffea_pkg::extent_t          newe_q, newe_d;
  logic [ffea_pkg::IdxW-1:0]  k_q, k_d;
  logic [ffea_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [ffea_pkg::CntW-1:0]  cnt_new_q, cnt_new_d;
  ffea_pkg::rsp_t             res_q, res_d;
  logic                       out_valid_q, out_valid_d;
  ffea_pkg::rsp_t             out_q, out_d;

  // ---------------------------------------------------------------- ring
  ffea_pkg::extent_t ext [N];
  ffea_pkg::extent_t push;
  ffea_pkg::extent_t init_ext;
  logic              shift_en;
  logic              init_load;

  for (genvar i = 0; i < N; i++) begin : g_cell
    ffea_pkg::extent_t nb;
    if (i == N - 1) begin : g_tail
      assign nb = push;
    end else begin : g_mid
      assign nb = ext[i+1];
    end
    ffea_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (shift_en),
      .shift_data_i(nb),
      .load_i      ((i == 0) && init_load),
      .load_data_i (init_ext),
      .ext_o       (ext[i])
    );
  end

  ffea_pkg::extent_t head, nxt;
  assign head = ext[0];
  assign nxt  = ext[1];

  // ---------------------------------------------------------------- request prep
  logic                       in_fire;
  logic [ffea_pkg::LenW-1:0]  lim;
  logic [ffea_pkg::SizeW-1:0] bs_in;
  logic [ffea_pkg::BytesW:0]  bytes_up;
  logic [ffea_pkg::LenW-1:0]  init_size;
  logic [ffea_pkg::GranW-1:0] room;
  logic                       init_ok;

  assign in_fire  = in_valid_i && in_ready_o;
  assign lim      = ffea_pkg::LenW'(1) << ffea_pkg::GranW;
  assign bytes_up = (ffea_pkg::BytesW+1)'(in_data_i.request_bytes) + (ffea_pkg::BytesW+1)'(15);

  always_comb begin
    logic [ffea_pkg::LenW-1:0] l;
    l = lim - ffea_pkg::LenW'(in_data_i.block_addr);
    bs_in = (ffea_pkg::LenW'(in_data_i.block_granules) > l) ?
            l[ffea_pkg::SizeW-1:0] : in_data_i.block_granules;
  end

  // init extent from configuration
  assign init_ok   = (len_q >= ffea_pkg::LenW'(2)) && (base_q != ffea_pkg::AddrMask);
  assign room      = ffea_pkg::AddrMask - base_q;
  assign init_size = len_q - ffea_pkg::LenW'(1);
  always_comb begin
    init_ext.start = base_q;
    init_ext.size  = (init_size > ffea_pkg::LenW'(room)) ? room : init_size[ffea_pkg::SizeW-1:0];
  end

  // ---------------------------------------------------------------- scan terms
  logic                      live, has_nxt;
  logic [ffea_pkg::SizeW+1:0] g2;
  logic [ffea_pkg::LenW-1:0] fwd_sz0, fwd_szn, m, back_end, back_sz;
  logic                      fwd0, pos0, posk, fwdk, backk;

  assign live    = ffea_pkg::CntW'(k_q) < cnt_q;
  assign has_nxt = (ffea_pkg::CntW'(k_q) + ffea_pkg::CntW'(1)) < cnt_q;
  assign g2      = (ffea_pkg::SizeW+2)'(g_q) + (ffea_pkg::SizeW+2)'(2);

  // forward merge at position 0 (prep cycle)
  assign fwd_sz0 = ffea_pkg::LenW'(bs_q) + ffea_pkg::LenW'(1) + ffea_pkg::LenW'(head.size);
  assign fwd0    = (cnt_q != '0) && (ffea_pkg::LenW'(head.start) == end_q) &&
                   (fwd_sz0 <= ffea_pkg::SizeMax);
  assign pos0    = (cnt_q == '0) || (head.start >= hdr_q);

  // insertion point after head
  assign fwd_szn  = ffea_pkg::LenW'(bs_q) + ffea_pkg::LenW'(1) + ffea_pkg::LenW'(nxt.size);
  assign posk     = (head.start < hdr_q) && (!has_nxt || (nxt.start >= hdr_q));
  assign fwdk     = has_nxt && (ffea_pkg::LenW'(nxt.start) == end_q) &&
                    (fwd_szn <= ffea_pkg::SizeMax);
  assign m        = fwdk ? fwd_szn : ffea_pkg::LenW'(bs_q);
  assign back_end = ffea_pkg::LenW'(head.start) + ffea_pkg::LenW'(1) + ffea_pkg::LenW'(head.size);
  assign back_sz  = ffea_pkg::LenW'(head.size) + ffea_pkg::LenW'(1) + m;
  assign backk    = (back_end == ffea_pkg::LenW'(hdr_q)) && (back_sz <= ffea_pkg::SizeMax);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    g_d         = g_q;
    bs_d        = bs_q;
    hdr_d       = hdr_q;
    end_d       = end_q;
    found_d     = found_q;
    pend_d      = pend_q;
    carry_d     = carry_q;
    newe_d      = newe_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    cnt_new_d   = cnt_new_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    push        = head;
    shift_en    = 1'b0;
    init_load   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      SIdle: begin
        if (in_fire) begin
          func_d    = in_data_i.func;
          g_d       = bytes_up[ffea_pkg::BytesW:4];
          bs_d      = bs_in;
          hdr_d     = in_data_i.block_addr - ffea_pkg::GranW'(1);
          end_d     = ffea_pkg::LenW'(in_data_i.block_addr) + ffea_pkg::LenW'(bs_in);
          found_d   = 1'b0;
          pend_d    = PCopy;
          k_d       = '0;
          cnt_new_d = cnt_q;
          res_d     = '0;
          case (in_data_i.func)
            ffea_pkg::FnAlloc: begin
              if (in_data_i.request_bytes == '0) begin
                res_d.status = ffea_pkg::StIgn;
                state_d      = SDone;
              end else begin
                res_d.status = ffea_pkg::StNoFit;
                state_d      = SScan;
              end
            end
            ffea_pkg::FnFree: begin
              if (in_data_i.block_addr == '0) begin
                res_d.status = ffea_pkg::StIgn;
                state_d      = SDone;
              end else begin
                res_d.status = ffea_pkg::StOk;
                state_d      = SPrep;
              end
            end
            ffea_pkg::FnInit: begin
              init_load    = init_ok;
              cnt_new_d    = init_ok ? ffea_pkg::CntW'(1) : '0;
              res_d.status = ffea_pkg::StOk;
              state_d      = SDone;
            end
            default: begin
              res_d.status = ffea_pkg::StIgn;
              state_d      = SDone;
            end
          endcase
        end
      end

      // free: decide the case where the block lands at position 0
      SPrep: begin
        state_d = SScan;
        if (fwd0) begin
          found_d = 1'b1;
          pend_d  = PSubst;
          newe_d  = '{start: hdr_q, size: fwd_sz0[ffea_pkg::SizeW-1:0]};
        end else if (pos0) begin
          found_d = 1'b1;
          if (cnt_q >= ffea_pkg::CntW'(N)) begin
            res_d.status = ffea_pkg::StFull;
            state_d      = SDone;
          end else begin
            pend_d    = PIns;
            newe_d    = '{start: hdr_q, size: bs_q};
            cnt_new_d = cnt_q + ffea_pkg::CntW'(1);
          end
        end
      end

      // one ring rotation, one entry per cycle
      SScan: begin
        shift_en = 1'b1;
        case (pend_q)
          PCopy: push = head;
          PSkip: push = nxt;
          PSubst: begin
            push   = newe_q;
            pend_d = PCopy;
          end
          PIns: begin
            push    = newe_q;
            carry_d = head;
            pend_d  = PCarry;
          end
          PCarry: begin
            push    = carry_q;
            carry_d = head;
          end
          default: push = head;
        endcase

        if (!found_q && live) begin
          if (func_q == ffea_pkg::FnAlloc) begin
            if (ffea_pkg::ReqGW'(head.size) >= g_q) begin
              found_d          = 1'b1;
              res_d.status     = ffea_pkg::StOk;
              res_d.grant_addr = head.start + ffea_pkg::GranW'(1);
              if ((ffea_pkg::SizeW+2)'(head.size) >= g2) begin
                push.start           = head.start + ffea_pkg::GranW'(1) +
                                       g_q[ffea_pkg::GranW-1:0];
                push.size            = head.size - g_q[ffea_pkg::SizeW-1:0] -
                                       ffea_pkg::SizeW'(1);
                res_d.grant_granules = g_q[ffea_pkg::SizeW-1:0];
              end else begin
                push                 = nxt;
                pend_d               = PSkip;
                res_d.grant_granules = head.size;
                cnt_new_d            = cnt_q - ffea_pkg::CntW'(1);
              end
            end
          end else if (posk) begin
            found_d = 1'b1;
            if (backk) begin
              push.size = back_sz[ffea_pkg::SizeW-1:0];
              if (fwdk) begin
                pend_d    = PSkip;
                cnt_new_d = cnt_q - ffea_pkg::CntW'(1);
              end
            end else if (fwdk) begin
              pend_d = PSubst;
              newe_d = '{start: hdr_q, size: m[ffea_pkg::SizeW-1:0]};
            end else if (cnt_q >= ffea_pkg::CntW'(N)) begin
              res_d.status = ffea_pkg::StFull;
            end else begin
              pend_d    = PIns;
              newe_d    = '{start: hdr_q, size: bs_q};
              cnt_new_d = cnt_q + ffea_pkg::CntW'(1);
            end
          end
        end

        k_d = k_q + ffea_pkg::IdxW'(1);
        if (k_q == ffea_pkg::IdxW'(N - 1)) begin
          state_d = SDone;
        end
      end

      // hand the result to the output register
      SDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          cnt_d       = cnt_new_q;
          state_d     = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    g_q       <= g_d;
    bs_q      <= bs_d;
    hdr_q     <= hdr_d;
    end_q     <= end_d;
    found_q   <= found_d;
    pend_q    <= pend_d;
    carry_q   <= carry_d;
    newe_q    <= newe_d;
    k_q       <= k_d;
    cnt_new_q <= cnt_new_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/ffea_cell.sv
// ----------------------------------------------------------------------------
// ffea_cell: one slot of the extent ring
// Takes its neighbor's extent when the ring shifts, or a direct load.
// ----------------------------------------------------------------------------
module ffea_cell (
  input  logic              clk_i,
  input  logic              shift_i,
  input  ffea_pkg::extent_t shift_data_i,
  input  logic              load_i,
  input  ffea_pkg::extent_t load_data_i,
  output ffea_pkg::extent_t ext_o
);

  ffea_pkg::extent_t ext_q, ext_d;

  // shift has priority over a direct load
  always_comb begin
    ext_d = ext_q;
    if (shift_i) begin
      ext_d = shift_data_i;
    end else if (load_i) begin
      ext_d = load_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ext_q <= ext_d;
  end

  assign ext_o = ext_q;

endmodule

// File: verif/first_fit_extent_allocator_core_test.sv
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_core_test: self-checking bench of the allocator
// Drives alloc/free/init beats with random bursts and gaps, stalls the result
// side on its own pattern, and checks every result against a local model of
// the free-extent table.
// ----------------------------------------------------------------------------
module first_fit_extent_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FnUnused = 2'd3;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  ffea_pkg::req_t in_data_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  ffea_pkg::rsp_t out_data_o;
  logic           psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  first_fit_extent_allocator_core i_dut (.*);

  always #10 clk_i = ~clk_i;

  // free-extent table model
  logic [ffea_pkg::GranW-1:0] free_start [ffea_pkg::MaxExtents];
  logic [ffea_pkg::SizeW-1:0] free_size  [ffea_pkg::MaxExtents];
  int                         free_count;
  logic [19:0]                cfg_base = 20'd1;
  logic [20:0]                cfg_len  = 21'd4096;
  ffea_pkg::rsp_t             pending_rsp [$];
  int                         fail_count = 0;
  int                         stall_mode = 0;
  bit                         gaps_on = 1'b1;
  // live blocks, for well-formed frees
  logic [19:0]                live_addr [$];
  logic [19:0]                live_gran [$];

  function automatic void table_remove(int i);
    for (int k = i; k + 1 < free_count; k++) begin
      free_start[k] = free_start[k+1];
      free_size[k]  = free_size[k+1];
    end
    free_count--;
  endfunction

  function automatic ffea_pkg::rsp_t predict_result(ffea_pkg::req_t r);
    ffea_pkg::rsp_t o;
    longint         a, bs, hdr, fin, g, s, sz, ln;
    int             pos;
    bit             fwd, back;
    o = '0;
    case (r.func)
      ffea_pkg::FnAlloc: begin
        if (r.request_bytes == 0) begin
          o.status = ffea_pkg::StIgn;
        end else begin
          g = (longint'(r.request_bytes) + 15) >> 4;
          o.status = ffea_pkg::StNoFit;
          for (int i = 0; i < free_count; i++) begin
            s = longint'(free_start[i]); sz = longint'(free_size[i]);
            if (sz < g) continue;
            o.status = ffea_pkg::StOk;
            o.grant_addr = 20'(s + 1);
            if (sz >= g + 2) begin
              free_start[i] = 20'(s + 1 + g);
              free_size[i]  = 20'(sz - g - 1);
              o.grant_granules = 20'(g);
            end else begin
              table_remove(i);
              o.grant_granules = 20'(sz);
            end
            break;
          end
        end
      end
      ffea_pkg::FnFree: begin
        a = longint'(r.block_addr); bs = longint'(r.block_granules);
        if (a == 0) begin
          o.status = ffea_pkg::StIgn;
        end else begin
          if (bs > 64'hFFFFF - a + 1) bs = 64'hFFFFF - a + 1;
          hdr = a - 1; fin = a + bs; pos = 0;
          while (pos < free_count && longint'(free_start[pos]) < hdr) pos++;
          fwd = pos < free_count && longint'(free_start[pos]) == fin &&
                bs + 1 + longint'(free_size[pos]) <= 64'hFFFFF;
          if (fwd) bs = bs + 1 + longint'(free_size[pos]);
          back = pos > 0 &&
                 longint'(free_start[pos-1]) + 1 + longint'(free_size[pos-1]) == hdr &&
                 longint'(free_size[pos-1]) + 1 + bs <= 64'hFFFFF;
          o.status = ffea_pkg::StOk;
          if (back) begin
            free_size[pos-1] = 20'(longint'(free_size[pos-1]) + 1 + bs);
            if (fwd) table_remove(pos);
          end else if (fwd) begin
            free_start[pos] = 20'(hdr); free_size[pos] = 20'(bs);
          end else if (free_count >= ffea_pkg::MaxExtents) begin
            o.status = ffea_pkg::StFull;
          end else begin
            for (int k = free_count; k > pos; k--) begin
              free_start[k] = free_start[k-1];
              free_size[k]  = free_size[k-1];
            end
            free_start[pos] = 20'(hdr); free_size[pos] = 20'(bs);
            free_count++;
          end
        end
      end
      ffea_pkg::FnInit: begin
        o.status = ffea_pkg::StOk;
        free_count = 0;
        s = longint'(cfg_base); ln = longint'(cfg_len);
        if (ln >= 2 && s < 64'hFFFFF) begin
          sz = ln - 1;
          if (sz > 64'hFFFFF - s) sz = 64'hFFFFF - s;
          free_start[0] = 20'(s); free_size[0] = 20'(sz); free_count = 1;
        end
        live_addr.delete(); live_gran.delete();
      end
      default: o.status = ffea_pkg::StIgn;
    endcase
    return o;
  endfunction

  // send one beat, with optional random gap first; valid stays up between
  // back-to-back beats
  task automatic send_beat(ffea_pkg::req_t r);
    ffea_pkg::rsp_t e;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    e = predict_result(r);
    pending_rsp.push_back(e);
    if (r.func == ffea_pkg::FnAlloc && e.status == ffea_pkg::StOk) begin
      live_addr.push_back(e.grant_addr);
      live_gran.push_back(e.grant_granules);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(int idx, logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * idx); pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == 0) cfg_base = v[19:0];
    else cfg_len = v[20:0];
    @(posedge clk_i);
  endtask

  function automatic ffea_pkg::req_t mk(int unsigned f, int unsigned b, int unsigned a,
                                        int unsigned g);
    ffea_pkg::req_t r;
    r.func = 2'(f); r.request_bytes = 24'(b); r.block_addr = 20'(a);
    r.block_granules = 20'(g);
    return r;
  endfunction

  // free a random live block and drop it from the list
  task automatic free_live();
    int k;
    k = $urandom_range(0, live_addr.size() - 1);
    send_beat(mk(ffea_pkg::FnFree, $urandom, live_addr[k], live_gran[k]));
    live_addr.delete(k); live_gran.delete(k);
  endtask

  // result checker with its own stall pattern
  always @(posedge clk_i) begin
    ffea_pkg::rsp_t e;
    if (out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data_o);
        fail_count++;
      end else begin
        e = pending_rsp.pop_front();
        if (out_data_o.status !== e.status)
          $display("%0t status exp %0d got %0d", $time, e.status, out_data_o.status);
        if (out_data_o.grant_addr !== e.grant_addr)
          $display("%0t grant_addr exp %h got %h", $time, e.grant_addr,
                   out_data_o.grant_addr);
        if (out_data_o.grant_granules !== e.grant_granules)
          $display("%0t grant_granules exp %h got %h", $time, e.grant_granules,
                   out_data_o.grant_granules);
        if (out_data_o !== e) fail_count++;
      end
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: out_ready_i <= ($urandom_range(0, 9) < 3);
    endcase
  end

  always @(posedge clk_i)
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);

  task automatic test_directed();
    send_beat(mk(ffea_pkg::FnAlloc, 24'd100, 0, 0));        // empty table: no fit
    send_beat(mk(ffea_pkg::FnInit, 0, 0, 0));
    send_beat(mk(ffea_pkg::FnAlloc, 24'd0, 0, 0));          // zero request
    send_beat(mk(ffea_pkg::FnAlloc, 24'hFFFFFF, 0, 0));     // oversized
    send_beat(mk(ffea_pkg::FnAlloc, 24'd1, 0, 0));
    send_beat(mk(ffea_pkg::FnAlloc, 24'd16, 0, 0));
    send_beat(mk(ffea_pkg::FnAlloc, 24'd17, 0, 0));
    send_beat(mk(ffea_pkg::FnFree, 0, 20'd0, 20'd5));       // null free
    send_beat(mk(FnUnused, 24'hFFFFFF, 20'hFFFFF, 20'hFFFFF));
    send_beat(mk(ffea_pkg::FnFree, 0, 20'd2, 20'd1));       // lands at position 0, no merge
    send_beat(mk(ffea_pkg::FnFree, 0, 20'd500, 20'd0));     // zero-size free
    send_beat(mk(ffea_pkg::FnFree, 0, 20'd500, 20'd3));     // double free
    send_beat(mk(ffea_pkg::FnFree, 0, 20'hFFFFF, 20'hFFFFF)); // size overrun
    send_beat(mk(ffea_pkg::FnAlloc, 24'd65536, 0, 0));
    send_beat(mk(ffea_pkg::FnAlloc, 24'd65504, 0, 0));      // larger than any free extent: no fit
    send_beat(mk(ffea_pkg::FnInit, 0, 0, 0));
    send_beat(mk(ffea_pkg::FnAlloc, 24'd65488, 0, 0));      // exact fit leaves one granule
    // fill the table: alternating frees into a fresh heap
    for (int i = 0; i < 36; i++)
      send_beat(mk(ffea_pkg::FnFree, 0, 8000 + 4 * i, 20'd1));
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(0, 32'h0); write_reg(1, 32'd2);
    send_beat(mk(ffea_pkg::FnInit, 0, 0, 0));
    send_beat(mk(ffea_pkg::FnAlloc, 24'd1, 0, 0));
    drain();
    write_reg(0, 32'hFFFFF); write_reg(1, 32'h1FFFFF);   // no room after header
    send_beat(mk(ffea_pkg::FnInit, 0, 0, 0));
    send_beat(mk(ffea_pkg::FnAlloc, 24'd1, 0, 0));
    drain();
    write_reg(0, 32'hFFFFE); write_reg(1, 32'd1);        // length below 2
    send_beat(mk(ffea_pkg::FnInit, 0, 0, 0));
    drain();
    write_reg(0, 32'h0); write_reg(1, 32'h100000);       // largest region
    send_beat(mk(ffea_pkg::FnInit, 0, 0, 0));
    send_beat(mk(ffea_pkg::FnAlloc, 24'hFFFFFF, 0, 0));
    send_beat(mk(ffea_pkg::FnFree, 0, 20'd1, 20'hFFFFF));          // whole-region free over the free extent
    drain();
  endtask

  task automatic test_random(int n, logic [19:0] base, logic [20:0] len);
    int c;
    write_reg(0, {12'd0, base}); write_reg(1, {11'd0, len});
    send_beat(mk(ffea_pkg::FnInit, 0, 0, 0));
    for (int i = 0; i < n; i++) begin
      gaps_on = (i % 200) < 150;
      c = $urandom_range(0, 99);
      if (c < 45)
        send_beat(mk(ffea_pkg::FnAlloc, ($urandom_range(0, 7) == 0) ? $urandom
                  : $urandom_range(0, 800), $urandom, $urandom));
      else if (c < 85 && live_addr.size() > 0)
        free_live();
      else if (c < 93)
        send_beat(mk(ffea_pkg::FnFree, $urandom, $urandom, $urandom_range(0, 40)));
      else if (c < 96)
        send_beat(mk(ffea_pkg::FnFree, $urandom, $urandom, $urandom));
      else if (c < 98)
        send_beat(mk(FnUnused, $urandom, $urandom, $urandom));
      else
        send_beat(mk(ffea_pkg::FnInit, $urandom, $urandom, $urandom));
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random(650, 20'd1, 21'd4096);
    test_random(650, 20'd100, 21'd600);
    test_random(650, 20'hF0000, 21'h1FFFFF);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

// File: first_fit_extent_allocator_core.f
hw/rtl/ffea_pkg.sv
hw/rtl/ffea_cell.sv
hw/rtl/first_fit_extent_allocator_core.sv
verif/first_fit_extent_allocator_core_test.sv
